// ===== sv/thf_pkg.sv =====
// Shared types, constants and the FNV-1a step for the text feature hasher.
// No dependencies.
package thf_pkg;

   localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
   localparam int MAX_DIMENSIONS = 4096;
   localparam int DIM_W = 13;
   localparam int SLOT_W = 12;
   localparam int WEIGHT_W = 10;
   localparam logic [3:0] LONG_TOKEN = 4'd9;
   localparam logic [3:0] MOD_STEPS = 4'd15;   // 16 passes of 4 bits over the hash

   // Q.8 weights: 0.35, 0.45, 1.0, 1.3 rounded to nearest
   localparam logic [WEIGHT_W-1:0] W_TRIGRAM = 10'd90;
   localparam logic [WEIGHT_W-1:0] W_SHORT = 10'd115;
   localparam logic [WEIGHT_W-1:0] W_NORMAL = 10'd256;
   localparam logic [WEIGHT_W-1:0] W_LONG = 10'd333;

   localparam logic [1:0] KIND_TRIGRAM = 2'd0;
   localparam logic [1:0] KIND_TOKEN = 2'd1;
   localparam logic [1:0] KIND_NONE = 2'd2;

   typedef enum logic [1:0] {
      CMD_TOKEN = 2'd0,   // token byte, already folded
      CMD_SEP = 2'd1,     // non-token byte other than zero
      CMD_END = 2'd2      // terminating zero byte
   } cmd_type;

   typedef struct packed {
      logic valid;
      cmd_type cmd;
      logic [7:0] data;
   } qitem_type;

   // FNV prime is 2^40 + 0x1B3
   function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
      logic [63:0] x;
      x = h ^ {56'd0, b};
      return (x << 40) + x * 64'h1B3;
   endfunction

endpackage

// ===== sv/thf_front.sv =====
// Front end: classifies and case-folds text bytes, holds them in a two-entry queue.
// Depends on thf_pkg.
module thf_front import thf_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_text_byte,
   output qitem_type head,
   input  logic pop
);

   logic [9:0] mem_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic push;
   logic is_tok;
   logic [7:0] folded;
   cmd_type cmd;

   always_comb begin
      is_tok = (req_text_byte >= 8'h30 && req_text_byte <= 8'h39) ||
               (req_text_byte >= 8'h61 && req_text_byte <= 8'h7A) ||
               (req_text_byte >= 8'h41 && req_text_byte <= 8'h5A) ||
               req_text_byte == 8'h5F || req_text_byte[7];
      folded = (req_text_byte >= 8'h41 && req_text_byte <= 8'h5A) ?
               req_text_byte + 8'd32 : req_text_byte;
      priority if (req_text_byte == 8'd0) cmd = CMD_END;
      else if (is_tok) cmd = CMD_TOKEN;
      else cmd = CMD_SEP;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push = req_valid && !req_stall;

   assign head.valid = (count_ff != 2'd0);
   assign head.cmd = cmd_type'(mem_ff[rd_ptr_ff][9:8]);
   assign head.data = mem_ff[rd_ptr_ff][7:0];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= {cmd, folded};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== sv/thf_back.sv =====
// Back end: token state, sequential trigram hashing, slot reduction, result register.
// Depends on thf_pkg.
module thf_back import thf_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  qitem_type head,
   output logic pop,
   input  logic [DIM_W-1:0] dims,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [SLOT_W-1:0] rsp_slot_index,
   output logic signed [WEIGHT_W-1:0] rsp_feature_weight,
   output logic [1:0] rsp_feature_kind,
   output logic rsp_end_of_text
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_TRI = 4'b0010,
      ST_MOD = 4'b0100,
      ST_OUT = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [63:0] hash_ff, hash_in;
   logic [3:0] cnt_ff, cnt_in;
   logic [7:0] win_ff [3];
   logic [7:0] win_in [3];
   logic [1:0] fill_ff, fill_in;
   logic [63:0] acc_ff, acc_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic [3:0] step_ff, step_in;
   logic [WEIGHT_W-1:0] wmag_ff, wmag_in;
   logic neg_ff, neg_in;
   logic [1:0] kind_ff, kind_in;
   logic eot_ff, eot_in;
   logic none_ff, none_in;
   logic out_valid_ff, out_valid_in;
   logic [SLOT_W-1:0] out_slot_ff, out_slot_in;
   logic [WEIGHT_W-1:0] out_weight_ff, out_weight_in;
   logic [1:0] out_kind_ff, out_kind_in;
   logic out_eot_ff, out_eot_in;
   logic [DIM_W-1:0] eff_dims;
   logic [DIM_W-1:0] r;
   logic [63:0] q;
   logic [63:0] g;
   logic out_free;

   always_comb begin
      if (dims == '0) eff_dims = DIM_W'(1);
      else if (dims > DIM_W'(MAX_DIMENSIONS)) eff_dims = DIM_W'(MAX_DIMENSIONS);
      else eff_dims = dims;
   end

   // four restoring-division steps per cycle
   always_comb begin
      r = {1'b0, rem_ff};
      q = acc_ff;
      for (int i = 0; i < 4; i++) begin
         r = {r[DIM_W-2:0], q[63]};
         q = q << 1;
         if (r >= eff_dims) r = r - eff_dims;
      end
   end

   assign g = fnv_step(acc_ff, win_ff[step_ff[1:0]]);
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      hash_in = hash_ff;
      cnt_in = cnt_ff;
      win_in = win_ff;
      fill_in = fill_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      wmag_in = wmag_ff;
      neg_in = neg_ff;
      kind_in = kind_ff;
      eot_in = eot_ff;
      none_in = none_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_slot_in = out_slot_ff;
      out_weight_in = out_weight_ff;
      out_kind_in = out_kind_ff;
      out_eot_in = out_eot_ff;
      pop = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               unique case (head.cmd)
                  CMD_TOKEN: begin
                     hash_in = fnv_step(hash_ff, head.data);
                     if (cnt_ff < LONG_TOKEN) cnt_in = cnt_ff + 4'd1;
                     win_in[0] = win_ff[1];
                     win_in[1] = win_ff[2];
                     win_in[2] = head.data;
                     if (fill_ff != 2'd3) fill_in = fill_ff + 2'd1;
                     if (fill_ff >= 2'd2) begin
                        acc_in = FNV_BASIS;
                        step_in = 4'd0;
                        state_in = ST_TRI;
                     end
                  end
                  CMD_SEP, CMD_END: begin
                     if (cnt_ff != 4'd0) begin
                        acc_in = hash_ff;
                        neg_in = ~hash_ff[0];
                        rem_in = '0;
                        step_in = 4'd0;
                        kind_in = KIND_TOKEN;
                        eot_in = (head.cmd == CMD_END);
                        none_in = 1'b0;
                        priority if (cnt_ff >= LONG_TOKEN) wmag_in = W_LONG;
                        else if (cnt_ff <= 4'd2) wmag_in = W_SHORT;
                        else wmag_in = W_NORMAL;
                        hash_in = FNV_BASIS;
                        cnt_in = 4'd0;
                        win_in[0] = 8'd0;
                        win_in[1] = 8'd0;
                        win_in[2] = 8'd0;
                        fill_in = 2'd0;
                        state_in = ST_MOD;
                     end else if (head.cmd == CMD_END) begin
                        none_in = 1'b1;
                        eot_in = 1'b1;
                        state_in = ST_OUT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_TRI: begin
            acc_in = g;
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd2) begin
               neg_in = ~g[0];
               rem_in = '0;
               step_in = 4'd0;
               wmag_in = W_TRIGRAM;
               kind_in = KIND_TRIGRAM;
               eot_in = 1'b0;
               none_in = 1'b0;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            acc_in = q;
            rem_in = r[SLOT_W-1:0];
            step_in = step_ff + 4'd1;
            if (step_ff == MOD_STEPS) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_eot_in = eot_ff;
               if (none_ff) begin
                  out_slot_in = '0;
                  out_weight_in = '0;
                  out_kind_in = KIND_NONE;
               end else begin
                  out_slot_in = rem_ff;
                  out_weight_in = neg_ff ? (~wmag_ff + 10'd1) : wmag_ff;
                  out_kind_in = kind_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
      wmag_ff <= wmag_in;
      neg_ff <= neg_in;
      kind_ff <= kind_in;
      eot_ff <= eot_in;
      none_ff <= none_in;
      out_slot_ff <= out_slot_in;
      out_weight_ff <= out_weight_in;
      out_kind_ff <= out_kind_in;
      out_eot_ff <= out_eot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hash_ff <= FNV_BASIS;
         cnt_ff <= 4'd0;
         win_ff[0] <= 8'd0;
         win_ff[1] <= 8'd0;
         win_ff[2] <= 8'd0;
         fill_ff <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         hash_ff <= hash_in;
         cnt_ff <= cnt_in;
         win_ff <= win_in;
         fill_ff <= fill_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_slot_index = out_slot_ff;
   assign rsp_feature_weight = out_weight_ff;
   assign rsp_feature_kind = out_kind_ff;
   assign rsp_end_of_text = out_eot_ff;

endmodule

// ===== sv/text_feature_hasher_top.sv =====
// Top level of the text feature hasher: dimension count register, front queue, back engine.
// Depends on thf_pkg, thf_front and thf_back.
//
// Text enters one byte per item; a zero byte ends the text and always yields one result
// flagged end_of_text. Bytes are queued (two entries) and processed one at a time by the
// back end. A token byte that gives no trigram is taken in the idle state; a trigram passes
// 3 hash steps, the reduction and the output register, a closing token the last two. The
// reduction modulo the dimension count is a shared restoring divider that retires 4 hash
// bits a cycle. A finished result waits in the output register while the queue keeps
// taking bytes until full. Write the dimension count only while no text is in flight.
module text_feature_hasher_top import thf_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_text_byte,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [SLOT_W-1:0] rsp_slot_index,
   output logic signed [WEIGHT_W-1:0] rsp_feature_weight,
   output logic [1:0] rsp_feature_kind,
   output logic rsp_end_of_text,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [DIM_W-1:0] csr_dimension_count
);

   logic [DIM_W-1:0] dims_ff;
   qitem_type head;
   logic pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= DIM_W'(256);
      end else if (csr_valid && csr_ready) begin
         dims_ff <= csr_dimension_count;
      end
   end

   thf_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_text_byte(req_text_byte),
      .head(head),
      .pop(pop)
   );

   thf_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .pop(pop),
      .dims(dims_ff),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_slot_index(rsp_slot_index),
      .rsp_feature_weight(rsp_feature_weight),
      .rsp_feature_kind(rsp_feature_kind),
      .rsp_end_of_text(rsp_end_of_text)
   );

endmodule

// ===== tb/sv/tb_text_feature_hasher_top.sv =====
// Self-checking testbench for text_feature_hasher_top: drives text bytes, predicts
// trigram/token features, checks every result in order. Depends on thf_pkg and the RTL.
module tb_text_feature_hasher_top;
   import thf_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
   localparam logic [1:0] KIND_UNTYPED = 2'd3;   // row carries no typed expectation

   logic clock, reset;
   logic req_valid, req_stall;
   logic [7:0] req_text_byte;
   logic rsp_valid, rsp_stall;
   logic [SLOT_W-1:0] rsp_slot_index;
   logic signed [WEIGHT_W-1:0] rsp_feature_weight;
   logic [1:0] rsp_feature_kind;
   logic rsp_end_of_text;
   logic csr_valid, csr_ready;
   logic [DIM_W-1:0] csr_dimension_count;

   text_feature_hasher_top dut (.*);

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [WEIGHT_W-1:0] weight;
      logic [1:0] kind;
      logic eot;
   } feature_type;

   typedef struct {
      logic [7:0] b;
      feature_type exp;
   } dir_row_type;

   localparam feature_type UNTYPED = '{slot: '0, weight: '0, kind: KIND_UNTYPED, eot: 1'b0};
   localparam feature_type END_ONLY = '{slot: '0, weight: '0, kind: KIND_NONE, eot: 1'b1};

   // predictor state
   logic [DIM_W-1:0] dims_reg;
   logic [63:0] tok_hash;
   int unsigned tok_len;
   logic [7:0] win [3];
   int unsigned win_fill;

   feature_type pending_features[$];
   int mismatches, checked, idle_pct_in, idle_pct_out;
   int n_trigram, n_token, n_none;
   bit hold_out;

   logic [DIM_W-1:0] dims_set [] = '{13'd4096, 13'd1, 13'd0, 13'd8191, 13'd7, 13'd1000};
   int pct_in [] = '{0, 60, 0, 60};
   int pct_out [] = '{0, 0, 60, 60};

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("timeout");
      $display("** text_feature_hasher_top: FAILED **");
      $finish;
   end

   function automatic logic [63:0] fnv_mix(logic [63:0] h, logic [7:0] b);
      return (h ^ {56'd0, b}) * FNV_PRIME;
   endfunction

   function automatic feature_type make_feature(logic [63:0] h, logic [WEIGHT_W-1:0] w,
                                                logic [1:0] kind, logic eot);
      feature_type f;
      logic [63:0] d;
      d = (dims_reg == 0) ? 64'd1 : (dims_reg > MAX_DIMENSIONS ? 64'd4096 : 64'(dims_reg));
      f.slot = SLOT_W'(h % d);
      f.weight = h[0] ? w : -w;
      f.kind = kind;
      f.eot = eot;
      return f;
   endfunction

   function automatic void clear_token();
      tok_hash = FNV_BASIS;
      tok_len = 0;
      win[0] = 0; win[1] = 0; win[2] = 0;
      win_fill = 0;
   endfunction

   // returns 1 and the feature when this byte yields one
   function automatic bit hash_byte(logic [7:0] b, output feature_type f);
      logic [7:0] c;
      logic [63:0] g;
      logic [WEIGHT_W-1:0] w;
      bit is_tok;
      f = '0;
      is_tok = (b >= "0" && b <= "9") || (b >= "a" && b <= "z") ||
               (b >= "A" && b <= "Z") || b == "_" || b >= 8'd128;
      if (is_tok) begin
         c = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
         tok_hash = fnv_mix(tok_hash, c);
         if (tok_len < LONG_TOKEN) tok_len++;
         win[0] = win[1]; win[1] = win[2]; win[2] = c;
         if (win_fill < 3) win_fill++;
         if (win_fill < 3) return 0;
         g = fnv_mix(fnv_mix(fnv_mix(FNV_BASIS, win[0]), win[1]), win[2]);
         f = make_feature(g, W_TRIGRAM, KIND_TRIGRAM, 1'b0);
         return 1;
      end
      if (tok_len > 0) begin
         w = tok_len >= LONG_TOKEN ? W_LONG : (tok_len <= 2 ? W_SHORT : W_NORMAL);
         f = make_feature(tok_hash, w, KIND_TOKEN, b == 0);
         clear_token();
         return 1;
      end
      if (b == 0) begin
         f.kind = KIND_NONE;
         f.eot = 1'b1;
         return 1;
      end
      return 0;
   endfunction

   // send one byte; a typed expectation replaces the predicted one
   task automatic send_byte(logic [7:0] b, feature_type typed = UNTYPED);
      feature_type f;
      bit has_result;
      while (idle_pct_in > 0 && $urandom_range(99) < idle_pct_in) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      has_result = hash_byte(b, f);
      if (typed.kind != KIND_UNTYPED) pending_features.push_back(typed);
      else if (has_result) pending_features.push_back(f);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_features.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (60) @(posedge clock);
   endtask

   task automatic write_dims(logic [DIM_W-1:0] v);
      csr_valid <= 1'b1;
      csr_dimension_count <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      dims_reg = v;
   endtask

   // receiver: random stall or long hold-off
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= hold_out || (idle_pct_out > 0 && $urandom_range(99) < idle_pct_out);
   end

   always @(posedge clock) begin
      feature_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_slot_index, rsp_feature_weight, rsp_feature_kind, rsp_end_of_text};
         checked++;
         if (pending_features.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_features.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: slot %0d/%0d weight %0d/%0d kind %0d/%0d eot %0d/%0d",
                     want.slot, got.slot, $signed(want.weight), $signed(got.weight),
                     want.kind, got.kind, want.eot, got.eot);
            end else if (got.kind == KIND_TRIGRAM) n_trigram++;
            else if (got.kind == KIND_TOKEN) n_token++;
            else n_none++;
         end
      end
   end

   // directed text; 0 ends texts; an empty text gives only the end marker
   dir_row_type directed [] = '{
      '{8'd0, END_ONLY}, '{"A", UNTYPED}, '{"b", UNTYPED}, '{"Z", UNTYPED},
      '{" ", UNTYPED}, '{"a", UNTYPED}, '{"_", UNTYPED}, '{8'hFF, UNTYPED},
      '{"9", UNTYPED}, '{8'h80, UNTYPED}, '{8'h01, UNTYPED}, '{"x", UNTYPED},
      '{8'h00, UNTYPED}, '{"0", UNTYPED}, '{"1", UNTYPED}, '{"2", UNTYPED},
      '{"3", UNTYPED}, '{"4", UNTYPED}, '{"5", UNTYPED}, '{"6", UNTYPED},
      '{"7", UNTYPED}, '{"8", UNTYPED}, '{"9", UNTYPED}, '{"@", UNTYPED},
      '{8'd0, END_ONLY}};

   // random byte biased toward token characters
   function automatic logic [7:0] rand_byte();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 8'("a" + $urandom_range(25));
      if (r < 65) return 8'("A" + $urandom_range(25));
      if (r < 72) return 8'("0" + $urandom_range(9));
      if (r < 78) return 8'($urandom_range(255, 128));
      if (r < 93) return " ";
      if (r < 97) return 8'($urandom_range(127, 1));
      return 8'd0;
   endfunction

   initial begin
      int sent;
      req_valid = 0; req_text_byte = 0; csr_valid = 0; csr_dimension_count = 0;
      hold_out = 0; idle_pct_in = 0; idle_pct_out = 0;
      mismatches = 0; checked = 0; n_trigram = 0; n_token = 0; n_none = 0;
      dims_reg = 13'd256;
      clear_token();
      reset = 1;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed[i]) send_byte(directed[i].b, directed[i].exp);
      drain();

      // long hold-off so the queue fills and stalls the sender
      hold_out = 1;
      fork
         begin
            repeat (400) @(posedge clock);
            hold_out = 0;
         end
         for (int i = 0; i < 40; i++) send_byte(rand_byte());
      join
      send_byte(8'd0);
      drain();

      sent = 0;
      for (int ph = 0; ph < dims_set.size(); ph++) begin
         write_dims(dims_set[ph]);
         for (int k = 0; k < 4; k++) begin
            idle_pct_in = (k == 3) ? 22 : pct_in[k];
            idle_pct_out = (k == 3) ? 22 : pct_out[k];
            repeat (75) begin
               send_byte(rand_byte());
               sent++;
            end
            send_byte(8'd0);
            idle_pct_in = 0;
            idle_pct_out = 0;
            drain();
         end
      end

      $display("ran %0d random bytes over %0d dimension settings, all idle mixes",
               sent, dims_set.size());
      $display("features checked: %0d trigram, %0d token, %0d end marker",
               n_trigram, n_token, n_none);
      if (mismatches == 0 && pending_features.size() == 0)
         $display("** text_feature_hasher_top: PASSED **");
      else begin
         $display("mismatches %0d, leftover %0d", mismatches, pending_features.size());
         $display("** text_feature_hasher_top: FAILED **");
      end
      $finish;
   end
endmodule
